>>> hdl/ialu_pkg.sv
// Shared types and constants for the 64-bit integer ALU.
// Used by every module in hdl/; depends on nothing.
package ialu_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned DIV_STEPS = DATA_W;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_SMUL = 5'd2,  OP_UMUL = 5'd3,
    OP_SDIV = 5'd4,  OP_UDIV = 5'd5,  OP_SMOD = 5'd6,  OP_UMOD = 5'd7,
    OP_AND  = 5'd8,  OP_OR   = 5'd9,  OP_XOR  = 5'd10, OP_SHL  = 5'd11,
    OP_SHR  = 5'd12, OP_ASHR = 5'd13, OP_EQ   = 5'd14, OP_NE   = 5'd15,
    OP_SLT  = 5'd16, OP_SLE  = 5'd17, OP_SGT  = 5'd18, OP_SGE  = 5'd19,
    OP_ULT  = 5'd20, OP_ULE  = 5'd21, OP_UGT  = 5'd22, OP_UGE  = 5'd23,
    OP_MOV  = 5'd24, OP_NEG  = 5'd25, OP_NOT  = 5'd26, OP_BOOL = 5'd27,
    OP_NBOOL = 5'd28, OP_ZEXT = 5'd29, OP_SEXT = 5'd30, OP_NONE = 5'd31
  } opcode_e;

  // One word as it travels down the divider chain.
  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              want_rem;
    logic              neg_out;
    logic              zero_div;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] dsr;
  } stage_t;

endpackage

>>> hdl/ialu_front.sv
// Front end: decodes the word, computes the combinational results, splits the
// multiply over two stages and prepares the divider chain. Uses ialu_pkg.
module ialu_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [4:0]                    cmd_i,
  input  logic [ialu_pkg::DATA_W-1:0]   operand_a_i,
  input  logic [ialu_pkg::DATA_W-1:0]   operand_b_i,
  input  logic [3:0]                    size_bytes_i,
  output ialu_pkg::stage_t              stage_o
);

  localparam int unsigned W = ialu_pkg::DATA_W;
  localparam int unsigned H = W / 2;

  function automatic logic [W-1:0] extend(input logic [W-1:0] a, input logic [3:0] sz,
                                          input logic sgn);
    logic [W-1:0] r;
    r = '0;
    unique case (sz)
      4'd0: r = '0;
      4'd1: r = sgn ? {{(W-8){a[7]}}, a[7:0]} : {{(W-8){1'b0}}, a[7:0]};
      4'd2: r = sgn ? {{(W-16){a[15]}}, a[15:0]} : {{(W-16){1'b0}}, a[15:0]};
      4'd3: r = sgn ? {{(W-24){a[23]}}, a[23:0]} : {{(W-24){1'b0}}, a[23:0]};
      4'd4: r = sgn ? {{(W-32){a[31]}}, a[31:0]} : {{(W-32){1'b0}}, a[31:0]};
      4'd5: r = sgn ? {{(W-40){a[39]}}, a[39:0]} : {{(W-40){1'b0}}, a[39:0]};
      4'd6: r = sgn ? {{(W-48){a[47]}}, a[47:0]} : {{(W-48){1'b0}}, a[47:0]};
      4'd7: r = sgn ? {{(W-56){a[55]}}, a[55:0]} : {{(W-56){1'b0}}, a[55:0]};
      default: r = a;
    endcase
    return r;
  endfunction

  ialu_pkg::opcode_e op;
  logic [W-1:0] a, b, simple_res, ma, mb;
  logic         slt, ult, is_signed_div;
  logic [5:0]   amt;

  ialu_pkg::stage_t s1_d, s1_q, s2_d, s2_q;
  logic           mul_d, mul_q;
  logic [W-1:0]   p_ll_d, p_ll_q;
  logic [H-1:0]   p_lh_d, p_lh_q, p_hl_d, p_hl_q;
  logic [W-1:0]   p_cross;

  assign op  = ialu_pkg::opcode_e'(cmd_i);
  assign a   = operand_a_i;
  assign b   = operand_b_i;
  assign amt = operand_b_i[5:0];
  assign slt = $signed(a) < $signed(b);
  assign ult = a < b;
  assign is_signed_div = (op == ialu_pkg::OP_SDIV) || (op == ialu_pkg::OP_SMOD);
  assign ma = (is_signed_div && a[W-1]) ? (~a + 1'b1) : a;
  assign mb = (is_signed_div && b[W-1]) ? (~b + 1'b1) : b;

  always_comb begin
    simple_res = '0;
    unique case (op)
      ialu_pkg::OP_ADD:   simple_res = a + b;
      ialu_pkg::OP_SUB:   simple_res = a - b;
      ialu_pkg::OP_AND:   simple_res = a & b;
      ialu_pkg::OP_OR:    simple_res = a | b;
      ialu_pkg::OP_XOR:   simple_res = a ^ b;
      ialu_pkg::OP_SHL:   simple_res = a << amt;
      ialu_pkg::OP_SHR:   simple_res = a >> amt;
      ialu_pkg::OP_ASHR:  simple_res = $unsigned($signed(a) >>> amt);
      ialu_pkg::OP_EQ:    simple_res = W'(a == b);
      ialu_pkg::OP_NE:    simple_res = W'(a != b);
      ialu_pkg::OP_SLT:   simple_res = W'(slt);
      ialu_pkg::OP_SLE:   simple_res = W'(slt || (a == b));
      ialu_pkg::OP_SGT:   simple_res = W'(!slt && (a != b));
      ialu_pkg::OP_SGE:   simple_res = W'(!slt);
      ialu_pkg::OP_ULT:   simple_res = W'(ult);
      ialu_pkg::OP_ULE:   simple_res = W'(ult || (a == b));
      ialu_pkg::OP_UGT:   simple_res = W'(!ult && (a != b));
      ialu_pkg::OP_UGE:   simple_res = W'(!ult);
      ialu_pkg::OP_MOV:   simple_res = a;
      ialu_pkg::OP_NEG:   simple_res = '0 - a;
      ialu_pkg::OP_NOT:   simple_res = ~a;
      ialu_pkg::OP_BOOL:  simple_res = W'(a != '0);
      ialu_pkg::OP_NBOOL: simple_res = W'(a == '0);
      ialu_pkg::OP_ZEXT:  simple_res = extend(a, size_bytes_i, 1'b0);
      ialu_pkg::OP_SEXT:  simple_res = extend(a, size_bytes_i, 1'b1);
      default:            simple_res = '0;
    endcase
  end

  always_comb begin
    s1_d          = '0;
    s1_d.valid    = valid_i;
    s1_d.is_div   = (op == ialu_pkg::OP_SDIV) || (op == ialu_pkg::OP_UDIV) ||
                    (op == ialu_pkg::OP_SMOD) || (op == ialu_pkg::OP_UMOD);
    s1_d.want_rem = (op == ialu_pkg::OP_SMOD) || (op == ialu_pkg::OP_UMOD);
    s1_d.neg_out  = is_signed_div &&
                    (s1_d.want_rem ? a[W-1] : (a[W-1] ^ b[W-1]));
    s1_d.zero_div = (b == '0);
    s1_d.res      = simple_res;
    s1_d.rem      = '0;
    s1_d.quo      = ma;
    s1_d.dsr      = mb;
    mul_d  = (op == ialu_pkg::OP_SMUL) || (op == ialu_pkg::OP_UMUL);
    p_ll_d = a[H-1:0] * b[H-1:0];
    p_lh_d = H'(a[H-1:0] * b[W-1:H]);
    p_hl_d = H'(a[W-1:H] * b[H-1:0]);
  end

  // Second stage: fold the partial products into the low word.
  assign p_cross = {p_lh_q + p_hl_q, {H{1'b0}}};

  always_comb begin
    s2_d = s1_q;
    if (mul_q) begin
      s2_d.res = p_ll_q + p_cross;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      mul_q  <= 1'b0;
      p_ll_q <= '0;
      p_lh_q <= '0;
      p_hl_q <= '0;
    end else if (adv_i) begin
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      mul_q  <= mul_d;
      p_ll_q <= p_ll_d;
      p_lh_q <= p_lh_d;
      p_hl_q <= p_hl_d;
    end
  end

  assign stage_o = s2_q;

endmodule

>>> hdl/ialu_div_cell.sv
// One restoring-division cell: retires one quotient bit per word per cycle
// while adv_i is high. Uses ialu_pkg.
module ialu_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  ialu_pkg::stage_t  stage_i,
  output ialu_pkg::stage_t  stage_o
);

  localparam int unsigned W = ialu_pkg::DATA_W;

  logic [W:0]   shifted, trial;
  logic         ge;
  ialu_pkg::stage_t st_d, st_q;

  assign shifted = {stage_i.rem, stage_i.quo[W-1]};
  assign trial   = shifted - {1'b0, stage_i.dsr};
  assign ge      = !trial[W];

  always_comb begin
    st_d     = stage_i;
    st_d.rem = ge ? trial[W-1:0] : shifted[W-1:0];
    st_d.quo = {stage_i.quo[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv_i) begin
      st_q <= st_d;
    end
  end

  assign stage_o = st_q;

endmodule

>>> hdl/ialu_back.sv
// Back end: sign-fixes quotient or remainder, selects the result and holds
// it in the output register. Uses ialu_pkg.
module ialu_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  ialu_pkg::stage_t             stage_i,
  output logic                         valid_o,
  output logic [ialu_pkg::DATA_W-1:0]  result_o
);

  localparam int unsigned W = ialu_pkg::DATA_W;

  logic [W-1:0] mag, fixed, res_d, res_q;
  logic         valid_q;

  assign mag   = stage_i.want_rem ? stage_i.rem : stage_i.quo;
  assign fixed = stage_i.neg_out ? ('0 - mag) : mag;

  always_comb begin
    priority if (!stage_i.is_div) begin
      res_d = stage_i.res;
    end else if (stage_i.zero_div) begin
      res_d = '0;
    end else begin
      res_d = fixed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

>>> hdl/integer_alu_64_fold.sv
// 64-bit integer ALU with a fully pipelined divider.
// Built from ialu_front, a chain of ialu_div_cell and ialu_back; uses ialu_pkg.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) takes one word per cycle while
//   in_ready_o is high: cmd_i, operand_a_i, operand_b_i and size_bytes_i.
//   Each word yields one result word on the output channel (out_valid_o /
//   out_ready_i, result_o). Every opcode passes through 67 register
//   stages: two front-end stages (the second one finishes the 64-bit
//   multiply from three 32x32 partial products), 64 division cells that
//   each retire one quotient bit, and the output register. Throughput is
//   one word per cycle while the chain is not stalled; words leave in order.
//   Every word walks the whole chain, so the divider cells set the latency.
//   Stall: when the output register holds a word the receiver has not
//   taken, the whole chain holds, empty slots included, and in_ready_o
//   drops; it advances again in the cycle the receiver takes that word.
//   Reset: clears all valid flags, so the block comes up empty and ready.
//   Divide or modulo by zero gives 0; minimum over minus one wraps, and its
//   modulo gives 0.
module integer_alu_64_fold (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [4:0]                   cmd_i,
  input  logic [ialu_pkg::DATA_W-1:0]  operand_a_i,
  input  logic [ialu_pkg::DATA_W-1:0]  operand_b_i,
  input  logic [3:0]                   size_bytes_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ialu_pkg::DATA_W-1:0]  result_o
);

  localparam int unsigned N = ialu_pkg::DIV_STEPS;

  ialu_pkg::stage_t chain [N+1];
  logic             adv;
  logic             out_valid;

  // Advance everything unless a finished word is still waiting.
  assign adv        = !out_valid || out_ready_i;
  assign in_ready_o = adv;

  ialu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (in_valid_i),
    .cmd_i        (cmd_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .size_bytes_i (size_bytes_i),
    .stage_o      (chain[0])
  );

  // Divider chain: one quotient bit per cell.
  for (genvar i = 0; i < N; i++) begin : g_cell
    ialu_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  ialu_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .stage_i  (chain[N]),
    .valid_o  (out_valid),
    .result_o (result_o)
  );

  assign out_valid_o = out_valid;

endmodule
